>>> rtl/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder: result burst type and fixed constants.
// Used by utf8sd_decode, utf8sd_outbuf, utf8_stream_decoder and its checker.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

  localparam int unsigned UnitW    = 21;
  localparam int unsigned MaxRes   = 4;
  localparam int unsigned CountW   = 3;
  localparam int unsigned IdxW     = 2;

  localparam logic [UnitW-1:0] Repl     = 21'h00FFFD;
  localparam logic [UnitW-1:0] HiSurr   = 21'h00D800;
  localparam logic [UnitW-1:0] LoSurr   = 21'h00DC00;
  localparam logic [UnitW-1:0] SuppBase = 21'h010000;
  localparam logic [UnitW-1:0] BmpMax   = 21'h00FFFF;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  typedef struct packed {
    logic [CountW-1:0]           count;
    logic [MaxRes-1:0][UnitW-1:0] units;
    logic [MaxRes-1:0]           reps;
    logic                        eos;
  } burst_t;

endpackage

`default_nettype wire

>>> rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: mode register, byte decoder and result buffer.
// Depends on utf8sd_pkg, utf8sd_decode and utf8sd_outbuf.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one UTF-8 byte per cycle while the result buffer is free and
// returns code points, or UTF-16 units with surrogate pairs when the mode bit is
// set. A byte that yields k results (replacements for a broken sequence, or a
// surrogate pair) holds the input until the last of them is taken, since the
// result buffer hands out one result per cycle while out_ready_i is high, up to
// four per byte. Bytes that only extend a pending sequence give no result. Write
// the mode bit only while no results are in flight.
module utf8_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_string_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      unit_o,
  output logic             replaced_o,
  output logic             run_last_o,
  output logic             string_done_o
);

  logic               mode_q;
  logic               in_fire;
  utf8sd_pkg::burst_t burst;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  utf8sd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (in_fire),
    .mode_i          (mode_q),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .burst_o         (burst)
  );

  utf8sd_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (in_fire),
    .burst_i       (burst),
    .free_o        (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .unit_o        (unit_o),
    .replaced_o    (replaced_o),
    .run_last_o    (run_last_o),
    .string_done_o (string_done_o)
  );

endmodule

`default_nettype wire

>>> rtl/utf8sd_decode.sv
// Sequence state registers and the single-pass decode of one input byte into a
// burst of up to four results. Depends on utf8sd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic              mode_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              end_of_string_i,
  output utf8sd_pkg::burst_t     burst_o
);

  logic [utf8sd_pkg::UnitW-1:0] pc_q, pc_d;
  logic [2:0]                   len_q, len_d;
  logic [1:0]                   br_q, br_d;

  logic [utf8sd_pkg::UnitW-1:0] pc_app;
  logic [1:0]                   br_inc;
  logic                         is_cont;
  logic [1:0]                   repl_cnt;
  logic                         tail_v;
  logic                         tail_rep;
  logic [utf8sd_pkg::UnitW-1:0] tail_cp;
  logic [utf8sd_pkg::UnitW-1:0] supp_v;
  logic                         split;
  logic                         fresh;
  logic [utf8sd_pkg::UnitW-1:0] lead_pc;
  logic [2:0]                   lead_len;

  assign is_cont = (data_byte_i[7:6] == 2'b10);
  assign pc_app  = {pc_q[utf8sd_pkg::UnitW-7:0], data_byte_i[5:0]};
  assign br_inc  = br_q + 2'd1;

  always_comb begin
    lead_pc  = '0;
    lead_len = utf8sd_pkg::LenNone;
    if (data_byte_i[7:5] == 3'b110) begin
      lead_pc  = {16'd0, data_byte_i[4:0]};
      lead_len = utf8sd_pkg::LenTwo;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_pc  = {17'd0, data_byte_i[3:0]};
      lead_len = utf8sd_pkg::LenThree;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_pc  = {18'd0, data_byte_i[2:0]};
      lead_len = utf8sd_pkg::LenFour;
    end
  end

  always_comb begin
    pc_d     = pc_q;
    len_d    = len_q;
    br_d     = br_q;
    repl_cnt = 2'd0;
    tail_v   = 1'b0;
    tail_rep = 1'b0;
    tail_cp  = '0;
    fresh    = 1'b0;
    if (len_q != utf8sd_pkg::LenNone) begin
      if (is_cont) begin
        if (({1'b0, br_inc} + 3'd1) >= len_q) begin
          tail_v  = 1'b1;
          tail_cp = pc_app;
          pc_d    = '0;
          len_d   = utf8sd_pkg::LenNone;
          br_d    = '0;
        end else if (end_of_string_i) begin
          repl_cnt = br_inc + 2'd1;
        end else begin
          pc_d = pc_app;
          br_d = br_inc;
        end
      end else begin
        repl_cnt = br_q + 2'd1;
        pc_d     = '0;
        len_d    = utf8sd_pkg::LenNone;
        br_d     = '0;
        fresh    = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (!data_byte_i[7]) begin
        tail_v  = 1'b1;
        tail_cp = {13'd0, data_byte_i};
      end else if (lead_len == utf8sd_pkg::LenNone || end_of_string_i) begin
        tail_v   = 1'b1;
        tail_rep = 1'b1;
        tail_cp  = utf8sd_pkg::Repl;
      end else begin
        pc_d  = lead_pc;
        len_d = lead_len;
        br_d  = '0;
      end
    end

    if (end_of_string_i) begin
      pc_d  = '0;
      len_d = utf8sd_pkg::LenNone;
      br_d  = '0;
    end
  end

  assign supp_v = tail_cp - utf8sd_pkg::SuppBase;
  assign split  = mode_i && (tail_cp > utf8sd_pkg::BmpMax);

  always_comb begin
    logic [1:0] tail_cnt;
    tail_cnt = tail_v ? (split ? 2'd2 : 2'd1) : 2'd0;
    burst_o.count = {1'b0, repl_cnt} + {1'b0, tail_cnt};
    burst_o.eos   = end_of_string_i;
    for (int i = 0; i < utf8sd_pkg::MaxRes; i++) begin
      burst_o.units[i] = utf8sd_pkg::Repl;
      burst_o.reps[i]  = 1'b1;
      if (i[1:0] == repl_cnt) begin
        burst_o.reps[i]  = tail_rep;
        burst_o.units[i] = split ? (utf8sd_pkg::HiSurr + {10'd0, supp_v[20:10]}) : tail_cp;
      end else if (i > int'(repl_cnt)) begin
        burst_o.reps[i]  = tail_rep;
        burst_o.units[i] = utf8sd_pkg::LoSurr + {11'd0, supp_v[9:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      len_q <= utf8sd_pkg::LenNone;
      br_q  <= '0;
    end else if (fire_i) begin
      pc_q  <= pc_d;
      len_q <= len_d;
      br_q  <= br_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8sd_outbuf.sv
// Result register that holds one burst and hands its results out one per cycle while out_ready_i is high.
// Depends on utf8sd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_outbuf (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  utf8sd_pkg::burst_t                 burst_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [utf8sd_pkg::UnitW-1:0]       unit_o,
  output logic                               replaced_o,
  output logic                               run_last_o,
  output logic                               string_done_o
);

  logic                            valid_q, valid_d;
  logic [utf8sd_pkg::IdxW-1:0]     idx_q, idx_d;
  utf8sd_pkg::burst_t              buf_q;
  logic                            last;
  logic                            take;

  assign last          = ({1'b0, idx_q} == (buf_q.count - 3'd1));
  assign take          = valid_q && out_ready_i;
  assign free_o        = !valid_q || (out_ready_i && last);
  assign out_valid_o   = valid_q;
  assign unit_o        = buf_q.units[idx_q];
  assign replaced_o    = buf_q.reps[idx_q];
  assign run_last_o    = last;
  assign string_done_o = last && buf_q.eos;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i && (burst_i.count != '0)) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && (burst_i.count != '0)) begin
      buf_q <= burst_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8sd_checker.sv
// Port-level checks for utf8_stream_decoder and the bind that attaches them.
// Depends on utf8sd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [20:0] unit_o,
  input wire logic        replaced_o,
  input wire logic        run_last_o,
  input wire logic        string_done_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(unit_o))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> run_last_o)
    else $error("string end not on the last result of an item");

  a_repl_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && replaced_o |-> unit_o == utf8sd_pkg::Repl)
    else $error("replacement flag on a value other than U+FFFD");

  a_burst_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("burst ended before its last result");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .unit_o        (unit_o),
  .replaced_o    (replaced_o),
  .run_last_o    (run_last_o),
  .string_done_o (string_done_o)
);

`default_nettype wire
